FILE: src/tun_pkg.sv
// shared constants, types and helpers of the triangle unit normal block
package tun_pkg;

  // field widths
  localparam int COORD_WIDTH  = 16;
  localparam int NORMAL_WIDTH = 16;

  // front datapath widths
  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int POS_W   = $clog2(MAG_W);

  // alignment puts the largest magnitude's top bit here
  localparam int ALIGN_TOP = 30;
  localparam int AL_W      = ALIGN_TOP + 1;

  // square root datapath
  localparam int SQ_W    = 2 * AL_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int SREM_W  = ROOT_W + 2;

  // divider datapath
  localparam int FRAC_W = NORMAL_WIDTH - 1;
  localparam int QUO_W  = NORMAL_WIDTH;
  localparam int DVD_W  = AL_W + FRAC_W + 1;
  localparam int DREM_W = ROOT_W;
  localparam logic [QUO_W-1:0] MAX_Q = QUO_W'((1 << FRAC_W) - 1);

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // classified request handed from front to back
  typedef struct packed {
    logic                      deg;
    logic [2:0]                neg;
    logic [2:0][AL_W-1:0]      a;
  } tun_item_t;

  // finished result
  typedef struct packed {
    logic                         deg;
    logic [2:0][NORMAL_WIDTH-1:0] n;
  } tun_result_t;

  // index of the highest set bit
  function automatic logic [POS_W-1:0] top_bit(input logic [MAG_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

endpackage

FILE: src/tun_front.sv
// front: edges, cross product, magnitudes and alignment
module tun_front import tun_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic signed [COORD_WIDTH-1:0] v1_x_i,
  input  logic signed [COORD_WIDTH-1:0] v1_y_i,
  input  logic signed [COORD_WIDTH-1:0] v1_z_i,
  input  logic signed [COORD_WIDTH-1:0] v2_x_i,
  input  logic signed [COORD_WIDTH-1:0] v2_y_i,
  input  logic signed [COORD_WIDTH-1:0] v2_z_i,
  input  logic signed [COORD_WIDTH-1:0] v3_x_i,
  input  logic signed [COORD_WIDTH-1:0] v3_y_i,
  input  logic signed [COORD_WIDTH-1:0] v3_z_i,
  output logic                          valid_o,
  output tun_item_t                     item_o
);

  logic [4:0] vld_q;

  logic signed [EDGE_W-1:0]  e1_d [3];
  logic signed [EDGE_W-1:0]  e2_d [3];
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [PROD_W-1:0]  p_q  [6];
  logic signed [CROSS_W-1:0] n_d  [3];
  logic [MAG_W-1:0]          mag_d [3];
  logic [MAG_W-1:0]          mag2_q [3];
  logic [MAG_W-1:0]          mag3_q [3];
  logic [MAG_W-1:0]          m_d;
  logic [MAG_W-1:0]          m_q;
  logic [2:0]                neg2_q, neg3_q;
  logic [POS_W-1:0]          pos;
  logic [MAG_W+ALIGN_TOP-1:0] wide [3];
  tun_item_t                 item_d, item_q;

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // edge vectors
  assign e1_d[0] = EDGE_W'(v2_x_i) - EDGE_W'(v1_x_i);
  assign e1_d[1] = EDGE_W'(v2_y_i) - EDGE_W'(v1_y_i);
  assign e1_d[2] = EDGE_W'(v2_z_i) - EDGE_W'(v1_z_i);
  assign e2_d[0] = EDGE_W'(v3_x_i) - EDGE_W'(v1_x_i);
  assign e2_d[1] = EDGE_W'(v3_y_i) - EDGE_W'(v1_y_i);
  assign e2_d[2] = EDGE_W'(v3_z_i) - EDGE_W'(v1_z_i);

  // cross product terms and differences
  always_comb begin
    n_d[0] = CROSS_W'(p_q[0]) - CROSS_W'(p_q[1]);
    n_d[1] = CROSS_W'(p_q[2]) - CROSS_W'(p_q[3]);
    n_d[2] = CROSS_W'(p_q[4]) - CROSS_W'(p_q[5]);
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = n_d[k][CROSS_W-1] ? MAG_W'(-n_d[k]) : MAG_W'(n_d[k]);
    end
  end

  // largest magnitude
  always_comb begin
    m_d = mag2_q[0];
    if (mag2_q[1] > m_d) m_d = mag2_q[1];
    if (mag2_q[2] > m_d) m_d = mag2_q[2];
  end

  // align so the largest magnitude tops out at the fixed bit
  always_comb begin
    pos        = top_bit(m_q);
    item_d.deg = (m_q == '0);
    item_d.neg = neg3_q;
    for (int k = 0; k < 3; k++) begin
      wide[k]     = {mag3_q[k], {ALIGN_TOP{1'b0}}};
      item_d.a[k] = AL_W'(wide[k] >> pos);
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= e1_d[k];
        e2_q[k] <= e2_d[k];
      end
      p_q[0] <= PROD_W'(e1_q[1]) * PROD_W'(e2_q[2]);
      p_q[1] <= PROD_W'(e2_q[1]) * PROD_W'(e1_q[2]);
      p_q[2] <= PROD_W'(e2_q[0]) * PROD_W'(e1_q[2]);
      p_q[3] <= PROD_W'(e1_q[0]) * PROD_W'(e2_q[2]);
      p_q[4] <= PROD_W'(e1_q[0]) * PROD_W'(e2_q[1]);
      p_q[5] <= PROD_W'(e2_q[0]) * PROD_W'(e1_q[1]);
      for (int k = 0; k < 3; k++) begin
        mag2_q[k] <= mag_d[k];
        neg2_q[k] <= n_d[k][CROSS_W-1];
        mag3_q[k] <= mag2_q[k];
      end
      neg3_q <= neg2_q;
      m_q    <= m_d;
      item_q <= item_d;
    end
  end

  assign valid_o = vld_q[4];
  assign item_o  = item_q;

endmodule

FILE: src/tun_fifo.sv
// short queue between front and back
module tun_fifo import tun_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tun_item_t item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output tun_item_t item_o
);

  tun_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign full_o  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

FILE: src/tun_back.sv
// back: sum of squares, pipelined square root and three pipelined dividers
module tun_back import tun_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  tun_item_t   item_i,
  output logic        valid_o,
  output tun_result_t result_o
);

  // squaring stage
  logic                  sq_v_q;
  tun_item_t             sq_tag_q;
  logic [2:0][SQ_W-1:0]  sq_q;

  // square root stages
  logic                  sr_v_q    [0:ROOT_W];
  tun_item_t             sr_tag_q  [0:ROOT_W];
  logic [SREM_W-1:0]     sr_rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0]     sr_root_q [0:ROOT_W];
  logic [SUM_W-1:0]      sr_rad_q  [0:ROOT_W];

  // divider stages
  logic                    dv_v_q   [0:QUO_W];
  tun_item_t               dv_tag_q [0:QUO_W];
  logic [ROOT_W-1:0]       dv_r_q   [0:QUO_W];
  logic [2:0][DREM_W-1:0]  dv_rem_q [0:QUO_W];
  logic [2:0][QUO_W-1:0]   dv_lo_q  [0:QUO_W];

  logic [2:0][DVD_W-1:0]   dvd;
  logic [QUO_W-1:0]        q_clamp [3];

  // square each aligned magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q <= 1'b0;
    else if (en_i) sq_v_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_tag_q <= item_i;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SQ_W'(item_i.a[k]) * SQ_W'(item_i.a[k]);
      end
    end
  end

  // sum of squares into the root pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sr_v_q[0] <= 1'b0;
    else if (en_i) sr_v_q[0] <= sq_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_tag_q[0]  <= sq_tag_q;
      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;
      sr_rad_q[0]  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
  end

  // one root bit per stage
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [SREM_W+1:0] rem_w, trial;
    logic              take;
    assign rem_w = {sr_rem_q[i], sr_rad_q[i][SUM_W-1 -: 2]};
    assign trial = (SREM_W+2)'({sr_root_q[i], 2'b01});
    assign take  = (rem_w >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_v_q[i+1] <= 1'b0;
      else if (en_i) sr_v_q[i+1] <= sr_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_tag_q[i+1]  <= sr_tag_q[i];
        sr_rad_q[i+1]  <= sr_rad_q[i] << 2;
        sr_rem_q[i+1]  <= take ? SREM_W'(rem_w - trial) : SREM_W'(rem_w);
        sr_root_q[i+1] <= {sr_root_q[i][ROOT_W-2:0], take};
      end
    end
  end

  // dividends with rounding offset of half the length
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvd[k] = (DVD_W'(sr_tag_q[ROOT_W].a[k]) << FRAC_W)
             + DVD_W'(sr_root_q[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else if (en_i) dv_v_q[0] <= sr_v_q[ROOT_W];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_tag_q[0] <= sr_tag_q[ROOT_W];
      dv_r_q[0]   <= sr_root_q[ROOT_W];
      for (int k = 0; k < 3; k++) begin
        dv_rem_q[0][k] <= DREM_W'(dvd[k][DVD_W-1:QUO_W]);
        dv_lo_q[0][k]  <= dvd[k][QUO_W-1:0];
      end
    end
  end

  // one quotient bit per stage, quotient shifts in behind the dividend
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [DREM_W:0] t [3];
    logic [2:0]      qb;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k]  = {dv_rem_q[j][k], dv_lo_q[j][k][QUO_W-1]};
        qb[k] = (t[k] >= (DREM_W+1)'(dv_r_q[j]));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j+1] <= 1'b0;
      else if (en_i) dv_v_q[j+1] <= dv_v_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_tag_q[j+1] <= dv_tag_q[j];
        dv_r_q[j+1]   <= dv_r_q[j];
        for (int k = 0; k < 3; k++) begin
          dv_rem_q[j+1][k] <= qb[k] ? DREM_W'(t[k] - (DREM_W+1)'(dv_r_q[j]))
                                    : DREM_W'(t[k]);
          dv_lo_q[j+1][k]  <= {dv_lo_q[j][k][QUO_W-2:0], qb[k]};
        end
      end
    end
  end

  // clamp, sign and degenerate override
  always_comb begin
    result_o.deg = dv_tag_q[QUO_W].deg;
    for (int k = 0; k < 3; k++) begin
      q_clamp[k] = (dv_lo_q[QUO_W][k] > MAX_Q) ? MAX_Q : dv_lo_q[QUO_W][k];
      if (dv_tag_q[QUO_W].deg) begin
        result_o.n[k] = '0;
      end else if (dv_tag_q[QUO_W].neg[k]) begin
        result_o.n[k] = NORMAL_WIDTH'(-q_clamp[k]);
      end else begin
        result_o.n[k] = NORMAL_WIDTH'(q_clamp[k]);
      end
    end
  end

  assign valid_o = dv_v_q[QUO_W];

endmodule

FILE: src/triangle_unit_normal_core.sv
// top level of the triangle unit normal block
//
// Takes three vertices per request on the input channel (in_valid_i /
// in_stall_o) and returns one unit face normal per request on the output
// channel (out_valid_o / out_stall_i), in request order. A request moves
// at a rising edge where valid is high and stall is low.
// Normal components are Q1.15, rounded to nearest, clamped to +/-32767.
// A zero cross product gives degenerate_o = 1 and all components zero.
// Throughput: one request per cycle while no stall holds the flow. With no
// stall a request passes 58 registers, the first loaded at the input
// edge: 5 front stages, the queue, then squares, sum, 32 square root
// stages (one root bit each), divider setup and 16 divider stages (one
// quotient bit each), and the output register. The square root and
// divider pipelines make up most of that depth.
// A stalling receiver freezes the back pipeline; a 4-entry queue lets the
// front keep accepting until it fills, then in_stall_o rises.
// Reset clears all valid bits and the queue pointers and count; data registers are not reset.
module triangle_unit_normal_core import tun_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  v1_x_i,
  input  logic signed [COORD_WIDTH-1:0]  v1_y_i,
  input  logic signed [COORD_WIDTH-1:0]  v1_z_i,
  input  logic signed [COORD_WIDTH-1:0]  v2_x_i,
  input  logic signed [COORD_WIDTH-1:0]  v2_y_i,
  input  logic signed [COORD_WIDTH-1:0]  v2_z_i,
  input  logic signed [COORD_WIDTH-1:0]  v3_x_i,
  input  logic signed [COORD_WIDTH-1:0]  v3_y_i,
  input  logic signed [COORD_WIDTH-1:0]  v3_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [NORMAL_WIDTH-1:0] normal_x_o,
  output logic signed [NORMAL_WIDTH-1:0] normal_y_o,
  output logic signed [NORMAL_WIDTH-1:0] normal_z_o,
  output logic                           degenerate_o
);

  logic        front_en, front_valid, push, fifo_full, fifo_valid, pop;
  logic        back_en, back_valid, out_valid_q;
  tun_item_t   front_item, fifo_item;
  tun_result_t back_result, out_q;

  // front advances unless its finished request cannot enter the queue
  assign front_en   = !(front_valid && fifo_full);
  assign in_stall_o = !front_en;
  assign push       = front_valid && !fifo_full;

  // back advances when the output register is free or being drained
  assign back_en = !out_valid_q || !out_stall_i;
  assign pop     = back_en && fifo_valid;

  tun_front u_front (
    .clk_i, .rst_ni,
    .en_i       (front_en),
    .in_valid_i,
    .v1_x_i, .v1_y_i, .v1_z_i,
    .v2_x_i, .v2_y_i, .v2_z_i,
    .v3_x_i, .v3_y_i, .v3_z_i,
    .valid_o    (front_valid),
    .item_o     (front_item)
  );

  tun_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  tun_back u_back (
    .clk_i, .rst_ni,
    .en_i     (back_en),
    .valid_i  (fifo_valid),
    .item_i   (fifo_item),
    .valid_o  (back_valid),
    .result_o (back_result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (back_en) out_valid_q <= back_valid;
  end
  always_ff @(posedge clk_i) begin
    if (back_en) out_q <= back_result;
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_q.n[0];
  assign normal_y_o   = out_q.n[1];
  assign normal_z_o   = out_q.n[2];
  assign degenerate_o = out_q.deg;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate result with nonzero normal");
  a_sym_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o != {1'b1, {(NORMAL_WIDTH-1){1'b0}}} &&
                     normal_y_o != {1'b1, {(NORMAL_WIDTH-1){1'b0}}} &&
                     normal_z_o != {1'b1, {(NORMAL_WIDTH-1){1'b0}}}))
    else $error("normal component beyond symmetric clamp");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(normal_x_o) && $stable(normal_y_o) &&
       $stable(normal_z_o) && $stable(degenerate_o)))
    else $error("stalled result changed");

endmodule
